// ===== sv/pgesc_pkg.sv =====
// Shared types and constants of the page escape update decoder.
package pgesc_pkg;

   localparam logic [7:0]  ESC_BYTE          = 8'h1B;
   localparam logic [7:0]  DIGIT_ZERO        = 8'd48;
   localparam logic [7:0]  DIGIT_NINE        = 8'd57;
   localparam logic [7:0]  CMD_MOVE          = 8'h60;
   localparam logic [7:0]  CMD_REPEAT        = 8'h62;
   localparam logic [7:0]  LAST_BYTE_RESET   = 8'h20;
   localparam logic [15:0] PAGE_LENGTH_RESET = 16'd1920;
   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_SKIP   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0] position;
      logic [15:0] run_length;
      logic [7:0]  fill_byte;
      logic        clipped;
   } run_type;

endpackage

// ===== sv/pgesc_if.sv =====
// Channel interfaces for the update byte stream and the write run stream.
interface pgesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] update_byte;
   logic       first;

   modport source (output valid, output update_byte, output first, input ready);
   modport sink   (input valid, input update_byte, input first, output ready);
endinterface

interface pgesc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] position;
   logic [15:0] run_length;
   logic [7:0]  fill_byte;
   logic        clipped;

   modport source (output valid, output position, output run_length,
                   output fill_byte, output clipped, input ready);
   modport sink   (input valid, input position, input run_length,
                   input fill_byte, input clipped, output ready);
endinterface

// ===== sv/page_escape_update_decoder_core.sv =====
// Top level of the page escape update decoder: page length register, parser and result stage.
// The decoder takes one update byte per clock while input ready is high, and turns
// it into at most one write run (position, length, fill byte, clipped flag) for
// a page store that already holds the old page. A byte's run is registered in the
// result register, or in the skid entry while that register is held, as the parse
// state and cursor update; bytes may arrive back to back. A two-entry result stage (the
// result register and one skid entry) lets the input keep going while a run
// waits; input ready drops only once both entries hold runs. The page length
// register resets to 1920 and should be written only while the decoder is idle.
module page_escape_update_decoder_core
   import pgesc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pgesc_req_if.sink   req_chan,
   pgesc_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] page_length_ff;
   logic        req_accept;
   logic        run_valid;
   run_type     run;
   run_type     out_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_length_ff <= PAGE_LENGTH_RESET;
      end else if (csr_wr_en) begin
         page_length_ff <= csr_wr_data;
      end
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   pgesc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .update_byte (req_chan.update_byte),
      .first       (req_chan.first),
      .page_length (page_length_ff),
      .run_valid   (run_valid),
      .run         (run)
   );

   pgesc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (run_valid),
      .in_run    (run),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_run   (out_run),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.position   = out_run.position;
   assign rsp_chan.run_length = out_run.run_length;
   assign rsp_chan.fill_byte  = out_run.fill_byte;
   assign rsp_chan.clipped    = out_run.clipped;

endmodule

// ===== sv/pgesc_parser.sv =====
// Escape parser state, cursor tracking and run clipping for one accepted byte per cycle.
module pgesc_parser
   import pgesc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  update_byte,
   input  logic        first,
   input  logic [15:0] page_length,
   output logic        run_valid,
   output run_type     run
);

   phase_type   phase_ff, phase_in, phase_eff;
   logic [15:0] cursor_ff, cursor_in, cursor_eff;
   logic [7:0]  last_ff, last_in;
   logic [15:0] count_ff, count_in, count_eff;
   logic [19:0] digit_sum;
   logic        is_digit;
   logic        emit;
   logic [15:0] want;
   logic [7:0]  fill;
   logic [16:0] advance;
   logic [15:0] avail;
   logic [15:0] len;

   always_comb begin
      // A first byte restarts the update before it is decoded.
      phase_eff  = first ? PH_NORMAL : phase_ff;
      cursor_eff = first ? 16'd0 : cursor_ff;
      count_eff  = first ? 16'd0 : count_ff;

      is_digit  = (update_byte >= DIGIT_ZERO) && (update_byte <= DIGIT_NINE);
      digit_sum = {1'b0, count_eff, 3'b000} + {3'b000, count_eff, 1'b0}
                + {16'd0, update_byte[3:0]};

      phase_in  = phase_ff;
      cursor_in = cursor_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      want      = 16'd0;
      fill      = last_ff;
      advance   = 17'd0;

      if (accept) begin
         phase_in  = phase_eff;
         cursor_in = cursor_eff;
         count_in  = count_eff;
         case (phase_eff)
            PH_SKIP: begin
               phase_in = PH_DIGITS;
               count_in = 16'd0;
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  count_in = (digit_sum > {4'd0, COUNT_MAX}) ? COUNT_MAX
                                                             : digit_sum[15:0];
               end else begin
                  phase_in = PH_NORMAL;
                  if (update_byte == CMD_MOVE) begin
                     cursor_in = count_eff;
                  end else if ((update_byte == CMD_REPEAT) && (count_eff > 16'd1)) begin
                     emit = 1'b1;
                     want = count_eff - 16'd1;
                     fill = last_ff;
                  end
               end
            end
            default: begin
               phase_in = PH_NORMAL;
               if (update_byte == ESC_BYTE) begin
                  phase_in = PH_SKIP;
                  count_in = 16'd0;
               end else begin
                  last_in = update_byte;
                  emit    = 1'b1;
                  want    = 16'd1;
                  fill    = update_byte;
               end
            end
         endcase

         if (emit) begin
            advance   = {1'b0, cursor_eff} + {1'b0, want};
            cursor_in = advance[16] ? COUNT_MAX : advance[15:0];
         end
      end

      // Runs stop at the page end; a cursor at or beyond it yields an empty run.
      avail = (cursor_eff < page_length) ? (page_length - cursor_eff) : 16'd0;
      len   = (want < avail) ? want : avail;

      run_valid      = accept && emit;
      run.position   = cursor_eff;
      run.run_length = len;
      run.fill_byte  = fill;
      run.clipped    = (len < want);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NORMAL;
         cursor_ff <= 16'd0;
         last_ff   <= LAST_BYTE_RESET;
         count_ff  <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         cursor_ff <= cursor_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/pgesc_out_stage.sv =====
// Result register with a skid entry so the input side can take one more run under stall.
module pgesc_out_stage
   import pgesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  run_type in_run,
   output logic    in_ready,
   output logic    out_valid,
   output run_type out_run,
   input  logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   run_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   run_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_in       = in_run;
         end
      end else if (in_valid) begin
         // The result register is held, so park the new transaction.
         skid_valid_in = 1'b1;
         skid_in       = in_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_run   = out_ff;

endmodule
